// ===== rtl/magic_word_frame_receiver_crc16_assert.svh =====
// Assertion macros for the magic word frame receiver.
// Depends on nothing; included by modules that carry concurrent assertions.
`ifndef MAGIC_WORD_FRAME_RECEIVER_CRC16_ASSERT_SVH
`define MAGIC_WORD_FRAME_RECEIVER_CRC16_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MWFR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MWFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mwfr_pkg.sv =====
// Types and constants for the magic word frame receiver.
// Depends on nothing; imported by the receiver top level.
package mwfr_pkg;

	// Frame parser phases.
	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_CRC_LO  = 2'd2,
		PH_CRC_HI  = 2'd3
	} phase_t;

	// Result error codes.
	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_CRC   = 2'd1,
		ERR_STATE = 2'd2
	} err_t;

	localparam logic [31:0] MAGIC          = 32'hAA55AA55;
	localparam logic [15:0] CRC_POLY       = 16'hA001;
	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [2:0]  HDR_LAST       = 3'd6;
	localparam int          HDR_KEPT       = 6;
	localparam int          PAYLOAD_BYTES  = 4;
	localparam logic [3:0]  TYPE_SET_STATE = 4'd4;
	localparam logic [7:0]  STATE_LIMIT_RST = 8'd8;

	// Payload length in bytes for each message type.
	localparam logic [3:0] LEN_OF_TYPE [16] = '{
		4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd4, 4'd4, 4'd4,
		4'd4, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
	};

	// One byte of reflected CRC-16/MODBUS.
	function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/magic_word_frame_receiver_crc16.sv =====
// A frame result is registered as its CRC high word leaves the input stage register.
// Throughput: one word per cycle; an input stage register feeds one pass of CRC and
// header logic into the state and a result register, so words keep flowing while a
// result waits. A stall occurs only if a CRC high word meets an untaken result.
// Reset: asynchronous, active low; parser restarts at the header, limit returns to 8.
// Depends on mwfr_pkg and magic_word_frame_receiver_crc16_assert.svh.
`include "magic_word_frame_receiver_crc16_assert.svh"

module magic_word_frame_receiver_crc16
	import mwfr_pkg::*;
#(
	parameter int MAX_PAYLOAD_BYTES = 4,
	parameter int NUM_TYPES         = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	// Received word channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	// Frame result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  msg_type,
	output logic [31:0] payload,
	output logic [2:0]  payload_len,
	output logic [1:0]  error_code
);

	// Payload length for a type, clamped to the largest supported payload.
	function automatic logic [3:0] exp_len(logic [3:0] t);
		logic [3:0] n;
		n = LEN_OF_TYPE[t];
		if (n > 4'(MAX_PAYLOAD_BYTES)) begin
			n = 4'(MAX_PAYLOAD_BYTES);
		end
		return n;
	endfunction

	logic [7:0]  state_limit_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	phase_t      phase_q, phase_d;
	logic [2:0]  count_q, count_d;
	logic [7:0]  hdr_q [HDR_KEPT];
	logic [7:0]  hdr_d [HDR_KEPT];
	logic [15:0] crc_q, crc_d;
	logic [31:0] pay_q, pay_d;
	logic [3:0]  type_q, type_d;
	logic [7:0]  crc_lo_q, crc_lo_d;
	logic        out_valid_q;
	logic [3:0]  out_type_q;
	logic [31:0] out_pay_q;
	logic [2:0]  out_len_q;
	err_t        out_err_q;
	logic        adv;
	logic        emit;
	err_t        err;
	logic [15:0] crc_upd;
	logic [3:0]  hdr_len;
	logic [3:0]  cur_len;
	logic        hdr_ok;

	// Configuration register is always writable.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_limit_q <= STATE_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			state_limit_q <= cfg_data;
		end
	end

	// The staged word moves on unless it closes a frame while an untaken result waits.
	assign adv      = valid_s1 && (phase_q != PH_CRC_HI || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	// Header checks on the six stored words plus the current one.
	assign crc_upd = crc16_byte(crc_q, byte_s1);
	assign hdr_len = exp_len(hdr_q[4][3:0]);
	assign cur_len = exp_len(type_q);
	assign hdr_ok  = ({hdr_q[3], hdr_q[2], hdr_q[1], hdr_q[0]} == MAGIC) &&
		(hdr_q[4] < 8'(NUM_TYPES)) && ({byte_s1, hdr_q[5]} == {12'h000, hdr_len});

	// Next state of the parser for the staged word.
	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		hdr_d    = hdr_q;
		crc_d    = crc_q;
		pay_d    = pay_q;
		type_d   = type_q;
		crc_lo_d = crc_lo_q;
		unique case (phase_q)
			PH_HEADER: begin
				for (int i = 0; i < HDR_KEPT; i++) begin
					if (count_q == 3'(i)) begin
						hdr_d[i] = byte_s1;
					end
				end
				crc_d   = crc_upd;
				count_d = count_q + 3'd1;
				if (count_q == HDR_LAST) begin
					count_d = 3'd0;
					pay_d   = '0;
					if (hdr_ok) begin
						type_d  = hdr_q[4][3:0];
						phase_d = (hdr_len == 4'd0) ? PH_CRC_LO : PH_PAYLOAD;
					end else begin
						crc_d  = CRC_INIT;
						type_d = '0;
					end
				end
			end
			PH_PAYLOAD: begin
				for (int i = 0; i < PAYLOAD_BYTES; i++) begin
					if (count_q == 3'(i)) begin
						pay_d[8*i +: 8] = byte_s1;
					end
				end
				crc_d   = crc_upd;
				count_d = count_q + 3'd1;
				if ({1'b0, count_d} >= cur_len) begin
					phase_d = PH_CRC_LO;
				end
			end
			PH_CRC_LO: begin
				crc_lo_d = byte_s1;
				phase_d  = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				phase_d  = PH_HEADER;
				count_d  = 3'd0;
				crc_d    = CRC_INIT;
				pay_d    = '0;
				type_d   = '0;
				crc_lo_d = '0;
			end
			default: begin
				phase_d = PH_HEADER;
			end
		endcase
	end

	// Result of a frame that ends with the staged word.
	always_comb begin
		emit = adv && (phase_q == PH_CRC_HI);
		if ({byte_s1, crc_lo_q} != crc_q) begin
			err = ERR_CRC;
		end else if (type_q == TYPE_SET_STATE && pay_q[7:0] >= state_limit_q) begin
			err = ERR_STATE;
		end else begin
			err = ERR_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			count_q  <= '0;
			crc_q    <= CRC_INIT;
			pay_q    <= '0;
			type_q   <= '0;
			crc_lo_q <= '0;
		end else if (adv) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			crc_q    <= crc_d;
			pay_q    <= pay_d;
			type_q   <= type_d;
			crc_lo_q <= crc_lo_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hdr_q <= hdr_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_type_q <= type_q;
			out_pay_q  <= pay_q;
			out_len_q  <= cur_len[2:0];
			out_err_q  <= err;
		end
	end

	assign out_valid   = out_valid_q;
	assign msg_type    = out_type_q;
	assign payload     = out_pay_q;
	assign payload_len = out_len_q;
	assign error_code  = out_err_q;

	// A closing word always leaves a result behind.
	`MWFR_ASSERT_NEXT(a_emit_lands, clk, arst_n, emit, out_valid_q, "result lost")
	// A frame with payload has a nonzero expected length.
	`MWFR_ASSERT_SAME(a_payload_len, clk, arst_n, phase_q == PH_PAYLOAD, cur_len != 4'd0,
		"payload phase with empty length")
	// Only accepted types get past the header.
	`MWFR_ASSERT_SAME(a_type_range, clk, arst_n, phase_q != PH_HEADER,
		{4'd0, type_q} < 8'(NUM_TYPES), "frame type out of range")
	// Header collection never runs past its last word.
	`MWFR_ASSERT_SAME(a_hdr_count, clk, arst_n, phase_q == PH_HEADER, count_q <= HDR_LAST,
		"header count overrun")

endmodule

// ===== dv/tb_magic_word_frame_receiver_crc16.sv =====
// Self-checking testbench for the magic word frame receiver with CRC-16 check.
// Depends on mwfr_pkg and magic_word_frame_receiver_crc16; predicts every frame
// result from the received words and compares each result field by field.
module tb_magic_word_frame_receiver_crc16;
	import mwfr_pkg::*;

	localparam int N_TYPES = 9;
	localparam int PAY_MAX = 4;
	localparam int HDR_LEN = 7;
	localparam int DRAIN_CYCLES = 10;
	localparam int CHUNK_WORDS = 100;
	localparam int CHUNK_FRAMES = 8;
	localparam logic [3:0] TYPE_GOAL_FIRST = 4'd5;
	localparam logic [3:0] TYPE_GOAL_LAST = 4'd8;

	typedef enum int {
		HDR_BAD_MAGIC,
		HDR_BAD_TYPE,
		HDR_BAD_LEN
	} hdr_fault_t;

	typedef struct {
		logic [3:0] mtype;
		logic [31:0] data;
		logic [2:0] len;
		err_t err;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_data = 8'h00;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] msg_type;
	logic [31:0] payload;
	logic [2:0] payload_len;
	logic [1:0] error_code;

	// Words waiting to be sent and frame results waiting to arrive.
	logic [7:0] rx_pending [$];
	frame_result_t pending_results [$];
	int rx_queued = 0;
	int rx_accepted = 0;
	int bad_results = 0;
	int idle_pct = 25;
	int in_gap = 0;
	int stall_left = 0;
	logic [15:0] gen_crc;

	// Parser state as the block should hold it.
	phase_t par_phase;
	int par_count;
	logic [55:0] par_hdr;
	logic [15:0] par_crc;
	logic [31:0] par_data;
	logic [3:0] par_type;
	logic [7:0] par_crc_lo;
	logic [7:0] par_limit;

	magic_word_frame_receiver_crc16 #(
		.MAX_PAYLOAD_BYTES(PAY_MAX),
		.NUM_TYPES(N_TYPES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.msg_type(msg_type),
		.payload(payload),
		.payload_len(payload_len),
		.error_code(error_code)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Reflected CRC-16, one data bit at a time, LSB first.
	function automatic logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// Payload length that a header must announce for a given type.
	function automatic int frame_len(logic [7:0] t);
		if (t == TYPE_SET_STATE) begin
			return 1;
		end
		if (t >= TYPE_GOAL_FIRST && t <= TYPE_GOAL_LAST) begin
			return PAY_MAX;
		end
		return 0;
	endfunction

	task automatic parser_restart();
		par_phase = PH_HEADER;
		par_count = 0;
		par_hdr = '0;
		par_crc = CRC_INIT;
		par_data = '0;
		par_type = '0;
		par_crc_lo = '0;
	endtask

	// Advance the parser by one accepted word and queue any frame result.
	task automatic parse_rx_byte(input logic [7:0] b);
		logic [7:0] t;
		logic [15:0] len;
		frame_result_t r;
		case (par_phase)
			PH_HEADER: begin
				par_hdr[8*par_count +: 8] = b;
				par_crc = crc_update(par_crc, b);
				par_count++;
				if (par_count == HDR_LEN) begin
					t = par_hdr[39:32];
					len = par_hdr[55:40];
					if (par_hdr[31:0] != MAGIC || t >= N_TYPES || len != 16'(frame_len(t))) begin
						parser_restart();
					end else begin
						par_type = t[3:0];
						par_count = 0;
						par_data = '0;
						if (frame_len(t) == 0) begin
							par_phase = PH_CRC_LO;
						end else begin
							par_phase = PH_PAYLOAD;
						end
					end
				end
			end
			PH_PAYLOAD: begin
				if (par_count < PAY_MAX) begin
					par_data[8*par_count +: 8] = b;
				end
				par_crc = crc_update(par_crc, b);
				par_count++;
				if (par_count >= frame_len({4'd0, par_type})) begin
					par_phase = PH_CRC_LO;
				end
			end
			PH_CRC_LO: begin
				par_crc_lo = b;
				par_phase = PH_CRC_HI;
			end
			default: begin
				r.mtype = par_type;
				r.data = par_data;
				r.len = 3'(frame_len({4'd0, par_type}));
				if ({b, par_crc_lo} != par_crc) begin
					r.err = ERR_CRC;
				end else if (par_type == TYPE_SET_STATE && par_data[7:0] >= par_limit) begin
					r.err = ERR_STATE;
				end else begin
					r.err = ERR_OK;
				end
				pending_results.push_back(r);
				parser_restart();
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			bad_results++;
		end
	endtask

	// Word driver: holds each word until it is taken, idles in bursts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				parse_rx_byte(rx_byte);
				rx_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (in_gap != 0) begin
					in_valid <= 1'b0;
					in_gap--;
				end else if (rx_pending.size() != 0) begin
					in_valid <= 1'b1;
					rx_byte <= rx_pending.pop_front();
					if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
						in_gap = $urandom_range(10, 1);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each taken result, stalls in bursts.
	always @(posedge clk) begin
		frame_result_t r;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual type %0h data %0h",
						$time, msg_type, payload);
					bad_results++;
				end else begin
					r = pending_results.pop_front();
					check_field("msg_type", 32'(r.mtype), 32'(msg_type));
					check_field("payload", r.data, payload);
					check_field("payload_len", 32'(r.len), 32'(payload_len));
					check_field("error_code", 32'(r.err), 32'(error_code));
				end
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
					stall_left = $urandom_range(10, 1);
				end
			end
		end
	end

	task automatic push_rx(input logic [7:0] b);
		rx_pending.push_back(b);
		rx_queued++;
		gen_crc = crc_update(gen_crc, b);
	endtask

	task automatic queue_header(input logic [31:0] magic, input logic [7:0] t,
			input logic [15:0] len);
		gen_crc = CRC_INIT;
		for (int i = 0; i < 4; i++) begin
			push_rx(magic[8*i +: 8]);
		end
		push_rx(t);
		push_rx(len[7:0]);
		push_rx(len[15:8]);
	endtask

	// A well-formed frame; a nonzero flip corrupts the transmitted CRC.
	task automatic queue_frame(input logic [7:0] t, input logic [31:0] data,
			input logic [15:0] crc_flip);
		int n;
		logic [15:0] c;
		n = frame_len(t);
		queue_header(MAGIC, t, 16'(n));
		for (int i = 0; i < n; i++) begin
			push_rx(data[8*i +: 8]);
		end
		c = gen_crc ^ crc_flip;
		push_rx(c[7:0]);
		push_rx(c[15:8]);
	endtask

	// A lone header that fails one of its checks.
	task automatic queue_bad_header();
		hdr_fault_t fault;
		logic [31:0] magic;
		logic [7:0] t;
		logic [15:0] len;
		int k;
		fault = hdr_fault_t'($urandom_range(2));
		magic = MAGIC;
		t = 8'($urandom_range(TYPE_GOAL_LAST, 0));
		len = 16'(frame_len(t));
		case (fault)
			HDR_BAD_MAGIC: begin
				k = $urandom_range(3);
				magic[8*k +: 8] ^= 8'($urandom_range(255, 1));
			end
			HDR_BAD_TYPE: begin
				t = 8'($urandom_range(255, N_TYPES));
			end
			default: begin
				len ^= 16'($urandom_range(65535, 1));
			end
		endcase
		queue_header(magic, t, len);
	endtask

	// Mostly good frames, some rejected headers, some line noise.
	task automatic queue_random_unit(inout int good);
		int pick;
		int n;
		logic [7:0] t;
		logic [31:0] data;
		logic [15:0] flip;
		pick = $urandom_range(99);
		if (pick < 72) begin
			if ($urandom_range(3) == 0) begin
				t = TYPE_SET_STATE;
			end else begin
				t = 8'($urandom_range(TYPE_GOAL_LAST, 0));
			end
			data = $urandom();
			if (t == TYPE_SET_STATE) begin
				case ($urandom_range(5))
					0: data[7:0] = par_limit - 8'd1;
					1: data[7:0] = par_limit;
					2: data[7:0] = par_limit + 8'd1;
					3: data[7:0] = 8'h00;
					4: data[7:0] = 8'hFF;
					default: data[7:0] = 8'($urandom());
				endcase
			end
			flip = ($urandom_range(99) < 15) ? 16'($urandom_range(65535, 1)) : 16'h0000;
			queue_frame(t, data, flip);
			good++;
		end else if (pick < 84) begin
			queue_bad_header();
		end else begin
			// Noise of a header's length keeps alignment; shorter noise breaks it.
			n = (pick < 95) ? HDR_LEN : $urandom_range(HDR_LEN - 1, 1);
			repeat (n) begin
				push_rx(8'($urandom()));
			end
		end
	endtask

	task automatic wait_drained();
		while (rx_accepted != rx_queued || pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Feed zero words until the parser waits for the start of a header.
	task automatic resync_parser();
		while (par_phase != PH_HEADER || par_count != 0) begin
			push_rx(8'h00);
			wait_drained();
		end
	endtask

	task automatic write_limit(input logic [7:0] v);
		@(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		par_limit = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [7:0] lim, input int pct);
		int start;
		int good;
		wait_drained();
		resync_parser();
		write_limit(lim);
		idle_pct = pct;
		start = rx_queued;
		good = 0;
		while (rx_queued - start < CHUNK_WORDS || good < CHUNK_FRAMES) begin
			queue_random_unit(good);
		end
	endtask

	initial begin
		parser_restart();
		par_limit = STATE_LIMIT_RST;

		// Set state exactly at the reset limit, then both errors at once,
		// then a header with the largest type byte.
		queue_frame(TYPE_SET_STATE, {24'h0, STATE_LIMIT_RST}, 16'h0000);
		queue_frame(TYPE_SET_STATE, 32'hFFFF_FFFF, 16'h0100);
		queue_header(MAGIC, 8'hFF, 16'h0000);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		run_phase(8'd1, 30);
		run_phase(8'd255, 0);
		run_phase(8'd0, 50);
		run_phase(8'($urandom_range(254, 2)), 0);

		wait_drained();
		if (bad_results == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mwfr_pkg.sv
rtl/magic_word_frame_receiver_crc16.sv
dv/tb_magic_word_frame_receiver_crc16.sv
